// File: hdl/lzbe_pkg.sv
// ----------------------------------------------------------------------------
// lzbe_pkg
// Shared types, sizes and the slot hash of the LZ78 byte encoder.
// ----------------------------------------------------------------------------
package lzbe_pkg;

  localparam int DICT_ENTRIES = 4096;
  localparam int SLOT_BITS    = $clog2(DICT_ENTRIES) + 1;
  localparam int SLOTS        = 1 << SLOT_BITS;
  localparam int FOLDS        = (24 + SLOT_BITS - 1) / SLOT_BITS;
  localparam int KEY_W        = FOLDS * SLOT_BITS;
  localparam int QUEUE_DEPTH  = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } item_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] prefix;
    logic [7:0]  symbol;
    logic [15:0] entry;
  } slot_t;

  typedef struct packed {
    logic clearing;
  } eng_status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CMP
  } eng_state_t;

  // fold the 24-bit key down to a slot address
  function automatic logic [SLOT_BITS-1:0] slot_hash(logic [15:0] pfx, logic [7:0] sym);
    logic [KEY_W-1:0]     k;
    logic [SLOT_BITS-1:0] h;
    k = KEY_W'({sym, pfx});
    h = '0;
    for (int i = 0; i < FOLDS; i++) begin
      h = h ^ k[i*SLOT_BITS +: SLOT_BITS];
    end
    return h;
  endfunction

endpackage

// File: hdl/lzbe_in_queue.sv
// ----------------------------------------------------------------------------
// lzbe_in_queue
// Small input queue between the accepting front and the dictionary engine.
// ----------------------------------------------------------------------------
module lzbe_in_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               enable,
  input  logic               push_valid,
  output logic               push_ready,
  input  lzbe_pkg::item_t    push_item,
  output logic               pop_valid,
  input  logic               pop,
  output lzbe_pkg::item_t    pop_item
);

  localparam int PW = $clog2(lzbe_pkg::QUEUE_DEPTH);

  lzbe_pkg::item_t     buf_r [lzbe_pkg::QUEUE_DEPTH];
  logic [PW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]         fill_r, fill_nxt;
  logic                do_push, do_pop;

  assign push_ready = enable && (fill_r != (PW+1)'(lzbe_pkg::QUEUE_DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_item   = buf_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(lzbe_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(lzbe_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      buf_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: hdl/lzbe_dict_engine.sv
// ----------------------------------------------------------------------------
// lzbe_dict_engine
// Hashed phrase table with linear probing, match tracking and result register.
// ----------------------------------------------------------------------------
module lzbe_dict_engine (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   item_valid,
  output logic                   item_pop,
  input  lzbe_pkg::item_t        item,
  output lzbe_pkg::eng_status_t  status,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [15:0]            out_phrase_index,
  output logic [7:0]             out_next_symbol,
  output logic                   out_stream_end
);

  localparam int SB = lzbe_pkg::SLOT_BITS;
  localparam logic [15:0] DICT_MAX = 16'(lzbe_pkg::DICT_ENTRIES);

  lzbe_pkg::slot_t     mem [lzbe_pkg::SLOTS];
  lzbe_pkg::slot_t     rd_data_r;

  lzbe_pkg::eng_state_t state_r, state_nxt;
  logic [SB-1:0] clr_r, clr_nxt;
  logic [SB-1:0] probe_r, probe_nxt;
  logic [7:0]    sym_r, sym_nxt;
  logic          last_r, last_nxt;
  logic [15:0]   match_r, match_nxt;
  logic [15:0]   count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [15:0]   out_idx_r, out_idx_nxt;
  logic [7:0]    out_sym_r, out_sym_nxt;
  logic          out_end_r, out_end_nxt;

  logic            rd_en, wr_en;
  logic [SB-1:0]   rd_addr, wr_addr;
  lzbe_pkg::slot_t wr_data;
  logic            out_free, hit;

  assign out_free = !out_valid_r || out_ready;
  assign hit = rd_data_r.valid && (rd_data_r.prefix == match_r) && (rd_data_r.symbol == sym_r);

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    probe_nxt     = probe_r;
    sym_nxt       = sym_r;
    last_nxt      = last_r;
    match_nxt     = match_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_idx_nxt   = out_idx_r;
    out_sym_nxt   = out_sym_r;
    out_end_nxt   = out_end_r;
    item_pop      = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = probe_r;
    wr_en         = 1'b0;
    wr_addr       = probe_r;
    wr_data       = '0;
    unique case (state_r)
      lzbe_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == SB'(lzbe_pkg::SLOTS - 1)) begin
          state_nxt = lzbe_pkg::ST_IDLE;
        end
      end
      lzbe_pkg::ST_IDLE: begin
        if (item_valid && out_free) begin
          item_pop  = 1'b1;
          sym_nxt   = item.data_byte;
          last_nxt  = item.final_byte;
          rd_en     = 1'b1;
          rd_addr   = lzbe_pkg::slot_hash(match_r, item.data_byte);
          probe_nxt = rd_addr;
          state_nxt = lzbe_pkg::ST_CMP;
        end
      end
      lzbe_pkg::ST_CMP: begin
        if (hit && !last_r) begin
          match_nxt = rd_data_r.entry;
          state_nxt = lzbe_pkg::ST_IDLE;
        end else if (hit || !rd_data_r.valid) begin
          // emit the pair; output register was free when the item was popped
          out_valid_nxt = 1'b1;
          out_idx_nxt   = match_r;
          out_sym_nxt   = sym_r;
          out_end_nxt   = last_r;
          match_nxt     = '0;
          state_nxt     = lzbe_pkg::ST_IDLE;
          if (!hit && (count_r < DICT_MAX)) begin
            wr_en          = 1'b1;
            wr_data.valid  = 1'b1;
            wr_data.prefix = match_r;
            wr_data.symbol = sym_r;
            wr_data.entry  = count_r + 16'd1;
            count_nxt      = count_r + 16'd1;
          end
        end else begin
          // collision: advance to the next slot
          rd_en     = 1'b1;
          rd_addr   = probe_r + 1'b1;
          probe_nxt = rd_addr;
        end
      end
      default: state_nxt = lzbe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lzbe_pkg::ST_CLEAR;
      clr_r       <= '0;
      match_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      match_r     <= match_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    probe_r   <= probe_nxt;
    sym_r     <= sym_nxt;
    last_r    <= last_nxt;
    out_idx_r <= out_idx_nxt;
    out_sym_r <= out_sym_nxt;
    out_end_r <= out_end_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign status.clearing  = (state_r == lzbe_pkg::ST_CLEAR);
  assign out_valid        = out_valid_r;
  assign out_phrase_index = out_idx_r;
  assign out_next_symbol  = out_sym_r;
  assign out_stream_end   = out_end_r;

endmodule

// File: hdl/lz78_byte_encoder_core.sv
// ----------------------------------------------------------------------------
// lz78_byte_encoder_core
// LZ78 encoder: one byte in, at most one (phrase, byte) pair out.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  in_     | input     | data_byte[7:0], final_byte
//  out_    | output    | phrase_index[15:0], next_symbol[7:0], stream_end
//
//  Each byte passes the engine's IDLE and CMP states, with one more probe in
//  CMP per hash collision; a hit's table entry feeds the next byte's lookup.
//  After reset all 2*4096 = 8192 slots are cleared, one slot a cycle,
//  with in_ready low.
//  A two-entry input queue and a result register let either side stall.
// ----------------------------------------------------------------------------
module lz78_byte_encoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_phrase_index,
  output logic [7:0]  out_next_symbol,
  output logic        out_stream_end
);

  lzbe_pkg::item_t       in_item, q_item;
  lzbe_pkg::eng_status_t status;
  logic                  q_valid, q_pop;

  assign in_item.data_byte  = in_data_byte;
  assign in_item.final_byte = in_final_byte;

  lzbe_in_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .enable     (!status.clearing),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_item  (in_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  lzbe_dict_engine u_engine (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_valid       (q_valid),
    .item_pop         (q_pop),
    .item             (q_item),
    .status           (status),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_phrase_index (out_phrase_index),
    .out_next_symbol  (out_next_symbol),
    .out_stream_end   (out_stream_end)
  );

endmodule

// File: hdl/lzbe_checker.sv
// ----------------------------------------------------------------------------
// lzbe_checker
// Port-level checks on the LZ78 encoder, bound to the top level.
// ----------------------------------------------------------------------------
module lzbe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_phrase_index
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_phrase_index))
    else $error("stalled result changed");

  // table clear keeps input closed right after reset
  a_clear_closed: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !in_ready && !out_valid)
    else $error("block open during table clear");

  // phrase index never exceeds the dictionary size
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_phrase_index) <= lzbe_pkg::DICT_ENTRIES))
    else $error("phrase index out of range");

endmodule

bind lz78_byte_encoder_core lzbe_checker u_lzbe_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_phrase_index (out_phrase_index)
);

// File: dv/lz78_pair_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz78_pair_checker
// Watches the byte and pair channels of the LZ78 encoder, predicts each
// emitted pair from its own copy of the dictionary, and counts mismatches.
// ----------------------------------------------------------------------------
module lz78_pair_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_final_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] out_phrase_index,
  input  logic [7:0]  out_next_symbol,
  input  logic        out_stream_end,
  output int          fail_count,
  output int          pending_pairs
);

  typedef struct {
    logic [15:0] phrase;
    logic [7:0]  symbol;
    logic        last;
  } pair_t;

  logic [15:0] dict_prefix [lzbe_pkg::DICT_ENTRIES];
  logic [7:0]  dict_symbol [lzbe_pkg::DICT_ENTRIES];
  int          dict_used;
  logic [15:0] cur_phrase;
  pair_t       pair_q[$];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic int lookup(input logic [15:0] pfx, input logic [7:0] sym);
    for (int n = 0; n < dict_used; n++)
      if (dict_prefix[n] == pfx && dict_symbol[n] == sym) return n + 1;
    return 0;
  endfunction

  task automatic encode_byte(input logic [7:0] sym, input logic last);
    int    hit;
    pair_t p;
    hit = lookup(cur_phrase, sym);
    if (hit != 0 && !last) begin
      cur_phrase = 16'(hit);
      return;
    end
    p.phrase = cur_phrase;
    p.symbol = sym;
    p.last   = last;
    pair_q.push_back(p);
    if (hit == 0 && dict_used < lzbe_pkg::DICT_ENTRIES) begin
      dict_prefix[dict_used] = cur_phrase;
      dict_symbol[dict_used] = sym;
      dict_used++;
    end
    cur_phrase = '0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fail_count    = 0;
      dict_used     = 0;
      cur_phrase    = '0;
      pair_q.delete();
      pending_pairs = 0;
    end else begin
      if (in_valid && in_ready) encode_byte(in_data_byte, in_final_byte);
      if (out_valid && out_ready) begin
        if (pair_q.size() == 0) begin
          report("unexpected pair", 32'(out_phrase_index), 32'd0);
        end else begin
          pair_t p;
          p = pair_q.pop_front();
          if (out_phrase_index !== p.phrase)
            report("phrase_index", 32'(out_phrase_index), 32'(p.phrase));
          if (out_next_symbol !== p.symbol)
            report("next_symbol", 32'(out_next_symbol), 32'(p.symbol));
          if (out_stream_end !== p.last)
            report("stream_end", 32'(out_stream_end), 32'(p.last));
        end
      end
      pending_pairs = pair_q.size();
    end
  end
endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives byte streams into the LZ78 encoder under varied stall patterns;
// the pair checker beside it predicts and compares every emitted pair.
// ----------------------------------------------------------------------------
module tb_top;
  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_final_byte;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_phrase_index;
  logic [7:0]  out_next_symbol;
  logic        out_stream_end;
  int          fail_count;
  int          pending_pairs;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_off_cycles;
  logic        hold_off_req;

  lz78_byte_encoder_core DUT (.*);

  lz78_pair_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("[lz78_byte_encoder_core] ERROR");
    $finish;
  end

  // receiver: random stalls, or one long hold-off once requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready       <= 1'b0;
      hold_off_cycles <= 0;
    end else if (hold_off_req && hold_off_cycles < 300) begin
      hold_off_cycles <= hold_off_cycles + 1;
      out_ready       <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // offer one byte and hold it until accepted
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_final_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // well-formed stream: bytes from the first alpha symbols; a small alphabet makes phrases grow
  task automatic send_stream(input int len, input int alpha);
    for (int i = 0; i < len; i++)
      send_byte(8'($urandom_range(alpha - 1)), i == len - 1);
  endtask

  initial begin
    int guard;
    in_valid = 0; in_data_byte = 0; in_final_byte = 0;
    rst_n = 0; hold_off_req = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    // directed: extremes, repeats that match, final byte that matches
    send_byte(8'h00, 0); send_byte(8'hFF, 0); send_byte(8'h00, 0);
    send_byte(8'h00, 0); send_byte(8'hFF, 0); send_byte(8'hFF, 1);
    send_byte(8'hAA, 0); send_byte(8'hAA, 0); send_byte(8'hAA, 1);
    send_byte(8'h55, 1); send_byte(8'h55, 1); send_byte(8'h00, 0);
    send_byte(8'hFF, 0); send_byte(8'h00, 0); send_byte(8'hFF, 1);
    // pressure: long receiver hold-off while the sender keeps offering
    hold_off_req <= 1'b1;
    send_stream(40, 256);
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 85 : (phase == 3) ? 27 : 0;
      recv_stall_pct = (phase == 2) ? 85 : (phase == 3) ? 27 : 0;
      repeat (13) begin
        case ($urandom_range(9))
          0:       send_stream($urandom_range(1, 8), 256);
          1, 2:    send_stream($urandom_range(10, 60), 2);
          default: send_stream($urandom_range(10, 50), $urandom_range(2, 6));
        endcase
      end
      // end-of-phase noise on the random items
      repeat (10) send_byte(8'($urandom), 1'($urandom));
    end
    send_idle_pct = 0;
    recv_stall_pct = 50;
    repeat (3) send_stream(30, 3);
    send_stream(20, 256);
    in_valid <= 1'b0;
    guard = 0;
    while (pending_pairs != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending_pairs == 0) begin
      $display("[lz78_byte_encoder_core] OK");
    end else begin
      $display("[lz78_byte_encoder_core] ERROR");
    end
    $finish;
  end
endmodule
